### hdl/qvd_pkg.sv
// ---------------------------------------------------------------------------
// qvd_pkg
// shared types and constants of the query vector distance engine
// ---------------------------------------------------------------------------
package qvd_pkg;

    // kind of an input beat
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_CAND = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic {
        REG_VECTOR_LENGTH = 1'b0,
        REG_METRIC_MODE   = 1'b1
    } t_reg_idx;

    typedef enum logic {
        METRIC_EUCLID = 1'b0,
        METRIC_DOT    = 1'b1
    } t_metric;

    // per-element control that travels with the operands
    typedef struct packed {
        t_metric mode;
        logic    last;
    } t_ctrl;

    localparam int          LEN_WIDTH   = 11;
    localparam int          CFG_WIDTH   = 11;
    localparam logic [10:0] LEN_RESET   = 11'd128;
    localparam int          ACC_WIDTH   = 48;
    localparam int          IDX_WIDTH   = 16;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_WIDTH  = 2;
    localparam int          QLVL_WIDTH  = 3;

endpackage

### hdl/query_vector_distance_engine_unit.sv
// ---------------------------------------------------------------------------
// query_vector_distance_engine_unit
// squared euclidean or one-minus-dot-product distance of candidate vectors
// against a stored query vector
// ---------------------------------------------------------------------------
// input stream: tuser[0] selects a query load (0) or a candidate element (1),
// tdata carries the signed q1.15 element. query beats fill the query store in
// order; candidate beats are paired with the query element at the same place.
// output stream: one beat per candidate after its last element, tdata holds
// the q18.30 distance in bits 47:0 and the wrapping candidate index in 63:48.
// configuration: i_cfg_we writes vector_length (index 0) or metric_mode
// (index 1) at once; write only while no result is pending.
// throughput: one element per cycle while the output is not stalled, set by the
// single multiply-accumulate path and the one read port of the query store.
// after the last element is taken, the result beat passes the store read, queue,
// operand register, multiply, accumulate and output register in that order.
// reset clears positions, accumulator, candidate index and queue, and sets
// length 128 and the euclidean metric; the query store is not cleared.
// when the receiver stalls the back part holds, the queue fills and
// s_axis_tready drops once four elements are in flight.
// ---------------------------------------------------------------------------
module query_vector_distance_engine_unit #(
    parameter int MAX_DIM    = 1024,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  qvd_pkg::t_reg_idx                  i_cfg_idx,
    input  logic [qvd_pkg::CFG_WIDTH-1:0]      i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((ELEM_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // element_value
    input  logic [0:0]                         s_axis_tuser,  // operation
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [63:0]                        m_axis_tdata   // distance, vector_index
);
    import qvd_pkg::*;

    localparam int DATA_WIDTH = ((ELEM_WIDTH + 7) / 8) * 8;
    localparam int CTRL_WIDTH = $bits(t_ctrl);
    localparam int QW         = 2 * ELEM_WIDTH + CTRL_WIDTH;

    logic                  w_push;
    logic [ELEM_WIDTH-1:0] w_f_query;
    logic [ELEM_WIDTH-1:0] w_f_elem;
    t_ctrl                 w_f_ctrl;
    logic [QW-1:0]         w_q_in;
    logic [QW-1:0]         w_q_out;
    logic                  w_pop;
    logic                  w_empty;
    logic [QLVL_WIDTH-1:0] w_level;
    logic [ELEM_WIDTH-1:0] w_b_query;
    logic [ELEM_WIDTH-1:0] w_b_elem;
    t_ctrl                 w_b_ctrl;

    qvd_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_level     (w_level),
        .o_push        (w_push),
        .o_query       (w_f_query),
        .o_elem        (w_f_elem),
        .o_ctrl        (w_f_ctrl)
    );

    assign w_q_in = {w_f_ctrl, w_f_elem, w_f_query};

    qvd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    assign w_b_query = w_q_out[ELEM_WIDTH-1:0];
    assign w_b_elem  = w_q_out[2*ELEM_WIDTH-1:ELEM_WIDTH];
    assign w_b_ctrl  = t_ctrl'(w_q_out[QW-1:2*ELEM_WIDTH]);

    qvd_back #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_query       (w_b_query),
        .i_elem        (w_b_elem),
        .i_ctrl        (w_b_ctrl),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### hdl/qvd_queue.sv
// ---------------------------------------------------------------------------
// qvd_queue
// short first-in first-out queue between the front and the back part
// ---------------------------------------------------------------------------
module qvd_queue #(
    parameter int WIDTH = 34
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_empty,
    output logic [qvd_pkg::QLVL_WIDTH-1:0] o_level
);
    import qvd_pkg::*;

    logic [WIDTH-1:0]      r_store [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr;
    logic [QLVL_WIDTH-1:0] r_level;
    logic [QLVL_WIDTH-1:0] n_level;
    logic                  w_full;

    assign w_full  = (r_level == QLVL_WIDTH'(QUEUE_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_level = r_level;
    assign o_data  = r_store[r_rd_ptr];

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && i_pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_level <= n_level;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && w_full && !i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

endmodule

### hdl/qvd_front.sv
// ---------------------------------------------------------------------------
// qvd_front
// accepts beats, holds configuration and the query store, and hands
// candidate elements with their query element to the queue
// ---------------------------------------------------------------------------
module qvd_front #(
    parameter int MAX_DIM    = 1024,
    parameter int ELEM_WIDTH = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  qvd_pkg::t_reg_idx              i_cfg_idx,
    input  logic [qvd_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [DATA_WIDTH-1:0]          s_axis_tdata,
    input  logic [0:0]                     s_axis_tuser,
    input  logic [qvd_pkg::QLVL_WIDTH-1:0] i_q_level,
    output logic                           o_push,
    output logic [ELEM_WIDTH-1:0]          o_query,
    output logic [ELEM_WIDTH-1:0]          o_elem,
    output qvd_pkg::t_ctrl                 o_ctrl
);
    import qvd_pkg::*;

    localparam int ADDR_WIDTH = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LEN_CAP    = (MAX_DIM < 2047) ? MAX_DIM : 2047;
    localparam logic [LEN_WIDTH-1:0] CAP_LEN = LEN_CAP[LEN_WIDTH-1:0];

    logic [ELEM_WIDTH-1:0] r_store [MAX_DIM];

    logic [LEN_WIDTH-1:0]  r_len;
    t_metric               r_mode;
    logic [LEN_WIDTH-1:0]  r_load_pos;
    logic [LEN_WIDTH-1:0]  n_load_pos;
    logic [LEN_WIDTH-1:0]  r_elem_pos;
    logic [LEN_WIDTH-1:0]  n_elem_pos;
    logic                  r_f_valid;
    logic [ELEM_WIDTH-1:0] r_query;
    logic [ELEM_WIDTH-1:0] r_elem;
    t_ctrl                 r_ctrl;

    logic [LEN_WIDTH-1:0]  w_alen;
    logic [LEN_WIDTH-1:0]  w_load_at;
    logic [LEN_WIDTH:0]    w_load_inc;
    logic [LEN_WIDTH-1:0]  w_read_at;
    logic [LEN_WIDTH:0]    w_elem_inc;
    logic                  w_last;
    logic                  w_accept;
    logic                  w_wr;
    logic                  w_rd;
    logic [QLVL_WIDTH:0]   w_busy;
    logic [ELEM_WIDTH-1:0] w_value;
    t_op                   w_op;

    assign w_op     = t_op'(s_axis_tuser[0]);
    assign w_value  = s_axis_tdata[ELEM_WIDTH-1:0];
    assign w_busy   = {1'b0, i_q_level} + {{QLVL_WIDTH{1'b0}}, r_f_valid};
    assign s_axis_tready = (w_busy < (QLVL_WIDTH+1)'(QUEUE_DEPTH));
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_wr     = w_accept && (w_op == OP_LOAD);
    assign w_rd     = w_accept && (w_op == OP_CAND);

    // length of zero acts as one, above the store depth as the depth
    always_comb begin
        if (r_len == '0) begin
            w_alen = LEN_WIDTH'(1);
        end else if (r_len > CAP_LEN) begin
            w_alen = CAP_LEN;
        end else begin
            w_alen = r_len;
        end
    end

    always_comb begin
        w_load_at  = (r_load_pos >= w_alen) ? '0 : r_load_pos;
        w_load_inc = {1'b0, w_load_at} + 1'b1;
        n_load_pos = (w_load_inc >= {1'b0, w_alen}) ? '0 : w_load_inc[LEN_WIDTH-1:0];
        w_read_at  = (r_elem_pos >= w_alen) ? (w_alen - 1'b1) : r_elem_pos;
        w_elem_inc = {1'b0, r_elem_pos} + 1'b1;
        w_last     = (w_elem_inc >= {1'b0, w_alen});
        n_elem_pos = w_last ? '0 : w_elem_inc[LEN_WIDTH-1:0];
    end

    // query store: one write per load beat, one registered read per candidate beat
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[ADDR_WIDTH'(w_load_at)] <= w_value;
        end
        if (w_rd) begin
            r_query     <= r_store[ADDR_WIDTH'(w_read_at)];
            r_elem      <= w_value;
            r_ctrl.mode <= r_mode;
            r_ctrl.last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_RESET;
            r_mode     <= METRIC_EUCLID;
            r_load_pos <= '0;
            r_elem_pos <= '0;
            r_f_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_VECTOR_LENGTH: r_len  <= i_cfg_data[LEN_WIDTH-1:0];
                    REG_METRIC_MODE:   r_mode <= t_metric'(i_cfg_data[0]);
                endcase
            end
            if (w_wr) begin
                r_load_pos <= n_load_pos;
            end
            if (w_rd) begin
                r_elem_pos <= n_elem_pos;
            end
            r_f_valid <= w_rd;
        end
    end

    assign o_push  = r_f_valid;
    assign o_query = r_query;
    assign o_elem  = r_elem;
    assign o_ctrl  = r_ctrl;

    a_cand_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd |=> o_push)
        else $error("candidate beat not forwarded to queue");

endmodule

### hdl/qvd_back.sv
// ---------------------------------------------------------------------------
// qvd_back
// multiply, accumulate and finish one distance per candidate vector
// ---------------------------------------------------------------------------
module qvd_back #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  logic [ELEM_WIDTH-1:0] i_query,
    input  logic [ELEM_WIDTH-1:0] i_elem,
    input  qvd_pkg::t_ctrl        i_ctrl,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata   // distance[47:0], vector_index[63:48]
);
    import qvd_pkg::*;

    localparam int OPW  = ELEM_WIDTH + 1;
    localparam int TW   = 2 * ELEM_WIDTH + 2;
    localparam logic [63:0] ONE_WIDE = 64'd1 << (2 * ELEM_WIDTH - 2);
    localparam logic [ACC_WIDTH-1:0] FIXED_ONE = ONE_WIDE[ACC_WIDTH-1:0];

    logic                    w_en;
    logic                    r_s1_valid;
    logic [ELEM_WIDTH-1:0]   r_s1_query;
    logic [ELEM_WIDTH-1:0]   r_s1_elem;
    t_ctrl                   r_s1_ctrl;
    logic                    r_s2_valid;
    logic signed [TW-1:0]    r_s2_term;
    t_ctrl                   r_s2_ctrl;
    logic [ACC_WIDTH-1:0]    r_acc;
    logic                    r_res_valid;
    logic [ACC_WIDTH-1:0]    r_res_sum;
    t_metric                 r_res_mode;
    logic                    r_out_valid;
    logic [ACC_WIDTH-1:0]    r_out_dist;
    logic [IDX_WIDTH-1:0]    r_out_idx;
    logic [IDX_WIDTH-1:0]    r_count;

    logic signed [OPW-1:0]   w_q;
    logic signed [OPW-1:0]   w_e;
    logic signed [OPW-1:0]   w_a;
    logic signed [OPW-1:0]   w_b;
    logic signed [TW-1:0]    w_term;
    logic signed [ACC_WIDTH-1:0] w_term_acc;
    logic [ACC_WIDTH-1:0]    w_sum;

    // whole back part holds while a finished result waits
    assign w_en  = !r_out_valid || m_axis_tready;
    assign o_pop = w_en && !i_empty;

    // one shared multiplier: difference squared or plain product
    always_comb begin
        w_q = $signed({r_s1_query[ELEM_WIDTH-1], r_s1_query});
        w_e = $signed({r_s1_elem[ELEM_WIDTH-1], r_s1_elem});
        unique case (r_s1_ctrl.mode)
            METRIC_EUCLID: begin
                w_a = w_q - w_e;
                w_b = w_q - w_e;
            end
            METRIC_DOT: begin
                w_a = w_q;
                w_b = w_e;
            end
        endcase
        w_term = TW'(w_a) * TW'(w_b);
    end

    assign w_term_acc = ACC_WIDTH'(r_s2_term);
    assign w_sum      = r_acc + w_term_acc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_query <= i_query;
            r_s1_elem  <= i_elem;
            r_s1_ctrl  <= i_ctrl;
            r_s2_term  <= w_term;
            r_s2_ctrl  <= r_s1_ctrl;
            if (r_s2_valid && r_s2_ctrl.last) begin
                r_res_sum  <= w_sum;
                r_res_mode <= r_s2_ctrl.mode;
            end
            if (r_res_valid) begin
                r_out_dist <= (r_res_mode == METRIC_DOT) ? (FIXED_ONE - r_res_sum)
                                                          : r_res_sum;
                r_out_idx  <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_count     <= '0;
        end else if (w_en) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_res_valid <= r_s2_valid && r_s2_ctrl.last;
            r_out_valid <= r_res_valid;
            if (r_s2_valid) begin
                r_acc <= r_s2_ctrl.last ? '0 : w_sum;
            end
            if (r_res_valid) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_idx, r_out_dist};

    a_acc_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_acc))
        else $error("accumulator moved while output stalled");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && w_en) |=> m_axis_tvalid)
        else $error("finished sum did not reach the output");

endmodule

### bench/query_vector_distance_engine_unit_tb.sv
// ---------------------------------------------------------------------------
// query_vector_distance_engine_unit_tb
// self-checking bench for the query vector distance engine
// ---------------------------------------------------------------------------
// query and candidate element beats are queued by a stimulus process and sent
// by a clocked driver. Each accepted beat advances a local copy of the
// engine's state, and every finished candidate queues its expected distance
// and index. A clocked receiver compares each output beat with the oldest
// expected one. Both sides idle at random. The stimulus runs from directed
// corner cases through a stalled input to random phases at changing lengths
// and metrics.
// ---------------------------------------------------------------------------
module query_vector_distance_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qvd_pkg::*;

    localparam int MAX_DIM = 1024;

    typedef struct {
        t_op         op;
        logic [15:0] value;
        int          gap;
    } t_elem_beat;

    typedef struct {
        logic [47:0] distance;
        logic [15:0] cand_index;
    } t_distance;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    t_reg_idx             i_cfg_idx = REG_VECTOR_LENGTH;
    logic [CFG_WIDTH-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;   // element_value
    logic [0:0]           s_axis_tuser = '0;   // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;        // distance, vector_index

    query_vector_distance_engine_unit #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (16)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // expected engine state
    logic [15:0]  query_mem  [MAX_DIM];
    bit           query_seen [MAX_DIM];
    int unsigned  load_pos = 0;
    int unsigned  elem_pos = 0;
    logic [47:0]  acc = '0;
    logic [15:0]  cand_idx = '0;
    logic [10:0]  len_reg = LEN_RESET;
    t_metric      metric = METRIC_EUCLID;

    t_elem_beat   pending_beats[$];
    t_distance    expected_distances[$];
    int           n_pushed = 0;
    int           n_taken = 0;
    int           n_results = 0;
    int           errors = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    int           rx_hold = 0;
    int           rx_wait = 0;
    int           tx_gap = 0;
    t_elem_beat   next_beat;
    t_distance    oldest;

    function automatic int unsigned active_len();
        if (len_reg == 0) return 1;
        if (len_reg > MAX_DIM) return MAX_DIM;
        return 32'(len_reg);
    endfunction

    task automatic advance_distance(input t_op op, input logic [15:0] raw);
        int unsigned        len;
        int unsigned        p;
        logic signed [15:0] q;
        logic signed [15:0] e;
        logic signed [16:0] diff;
        logic signed [47:0] term;
        t_distance          r;
        len = active_len();
        e = raw;
        if (op == OP_LOAD) begin
            p = (load_pos >= len) ? 0 : load_pos;
            query_mem[p] = e;
            query_seen[p] = 1'b1;
            load_pos = (p + 1 >= len) ? 0 : p + 1;
        end else begin
            // a position past a lowered length reads the last query element
            p = (elem_pos >= len) ? len - 1 : elem_pos;
            q = query_mem[p];
            if (metric == METRIC_EUCLID) begin
                diff = 17'(q) - 17'(e);
                term = 48'(diff) * 48'(diff);
            end else begin
                term = 48'(q) * 48'(e);
            end
            acc = acc + term;
            if (elem_pos + 1 >= len) begin
                r.distance = (metric == METRIC_DOT) ? (48'd1 << 30) - acc : acc;
                r.cand_index = cand_idx;
                expected_distances.push_back(r);
                cand_idx = cand_idx + 1'b1;
                acc = '0;
                elem_pos = 0;
            end else begin
                elem_pos = elem_pos + 1;
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_distance(t_op'(s_axis_tuser[0]), s_axis_tdata);
                n_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    next_beat = pending_beats.pop_front();
                    tx_gap = next_beat.gap;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_beat.value;
                    s_axis_tuser <= next_beat.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_distances.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected: expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    oldest = expected_distances.pop_front();
                    if (m_axis_tdata[47:0] !== oldest.distance) begin
                        errors++;
                        $display("%0t: distance mismatch: expected %h actual %h",
                                 $time, oldest.distance, m_axis_tdata[47:0]);
                    end
                    if (m_axis_tdata[63:48] !== oldest.cand_index) begin
                        errors++;
                        $display("%0t: vector_index mismatch: expected %0d actual %0d",
                                 $time, oldest.cand_index, m_axis_tdata[63:48]);
                    end
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] rand_elem();
        unique case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_beat(input t_op op, input logic [15:0] v);
        t_elem_beat b;
        b.op = op;
        b.value = v;
        b.gap = tx_calm ? 0 : $urandom_range(0, 7);
        pending_beats.push_back(b);
        n_pushed++;
    endtask

    // called on a rising edge while idle
    task automatic set_regs(input logic [10:0] len, input t_metric mode);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_VECTOR_LENGTH;
        i_cfg_data <= len;
        @(posedge i_clk);
        len_reg = len;
        i_cfg_idx <= REG_METRIC_MODE;
        i_cfg_data <= {10'd0, mode};
        @(posedge i_clk);
        metric = mode;
        i_cfg_we <= 1'b0;
    endtask

    // all beats taken, all distances seen, then let non-final elements drain
    task automatic wait_idle();
        while (n_taken != n_pushed || expected_distances.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // every query entry in the active length must be written before it is read
    task automatic fill_query();
        int unsigned len;
        bit          hole;
        len = active_len();
        hole = 1'b0;
        for (int i = 0; i < len; i++)
            if (!query_seen[i]) hole = 1'b1;
        if (hole)
            for (int i = 0; i < len; i++) push_beat(OP_LOAD, rand_elem());
    endtask

    initial begin
        int          rand_beats;
        int          first;
        int          sel;
        int          len;
        int          ncand;
        logic [10:0] new_len;
        rand_beats = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: length 128, squared euclidean
        fill_query();
        for (int i = 0; i < 128; i++) push_beat(OP_CAND, rand_elem());
        wait_idle();

        // extreme values, both metrics
        set_regs(11'd4, METRIC_EUCLID);
        push_beat(OP_LOAD, 16'h7fff);
        push_beat(OP_LOAD, 16'h8000);
        push_beat(OP_LOAD, 16'h0000);
        push_beat(OP_LOAD, 16'hffff);
        push_beat(OP_CAND, 16'h8000);
        push_beat(OP_CAND, 16'h7fff);
        push_beat(OP_CAND, 16'h0000);
        push_beat(OP_CAND, 16'h0001);
        push_beat(OP_CAND, 16'h7fff);
        push_beat(OP_CAND, 16'h8000);
        push_beat(OP_CAND, 16'h0000);
        push_beat(OP_CAND, 16'hffff);
        wait_idle();
        set_regs(11'd4, METRIC_DOT);
        push_beat(OP_CAND, 16'h7fff);
        push_beat(OP_CAND, 16'h8000);
        push_beat(OP_CAND, 16'h0000);
        push_beat(OP_CAND, 16'hffff);
        // half a candidate, then the length drops below its position
        push_beat(OP_CAND, 16'h1234);
        push_beat(OP_CAND, 16'hedcb);
        wait_idle();
        set_regs(11'd2, METRIC_EUCLID);
        push_beat(OP_CAND, 16'h4000);
        wait_idle();
        // load pointer left beyond a lowered length restarts at zero
        set_regs(11'd4, METRIC_EUCLID);
        push_beat(OP_LOAD, 16'h0100);
        push_beat(OP_LOAD, 16'hff00);
        push_beat(OP_LOAD, 16'h7fff);
        wait_idle();
        set_regs(11'd2, METRIC_EUCLID);
        push_beat(OP_LOAD, 16'h8000);
        push_beat(OP_CAND, 16'h7fff);
        push_beat(OP_CAND, 16'h0101);
        wait_idle();
        // zero length acts as one
        set_regs(11'd0, METRIC_DOT);
        push_beat(OP_CAND, 16'h8000);
        wait_idle();

        // receiver holds off long enough for the engine to stall its input
        set_regs(11'd1, METRIC_EUCLID);
        tx_calm = 1'b1;
        rx_hold = 300;
        for (int i = 0; i < 64; i++) push_beat(OP_CAND, rand_elem());
        wait_idle();

        while (rand_beats < 950) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) new_len = 11'd0;
            else if (sel < 14) new_len = 11'($urandom_range(1, 16));
            else if (sel < 19) new_len = 11'($urandom_range(17, 64));
            else new_len = 11'($urandom_range(65, 96));
            set_regs(new_len, t_metric'($urandom_range(0, 1)));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            first = n_pushed;
            fill_query();
            len = active_len();
            ncand = $urandom_range(1, 6);
            for (int c = 0; c < ncand; c++) begin
                for (int e = 0; e < len; e++) begin
                    if ($urandom_range(0, 9) == 0) push_beat(OP_LOAD, rand_elem());
                    push_beat(OP_CAND, rand_elem());
                end
            end
            // leave a candidate unfinished across the next register change
            if ($urandom_range(0, 4) == 0)
                for (int e = $urandom_range(1, len); e < len; e++)
                    push_beat(OP_CAND, rand_elem());
            rand_beats += n_pushed - first;
            wait_idle();
        end

        $display("covered %0d element beats in and %0d distances out", n_taken, n_results);
        $display("lengths 0 to 128, both metrics, extreme values and a stalled input");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
